>>> src/escq_pkg.sv
// ----------------------------------------------------------------------------
// escq_pkg
// Types and constants shared by the escape/quote/macro filter.
// ----------------------------------------------------------------------------
`default_nettype none

package escq_pkg;

    // Largest output buffer size honoured by the limit
    localparam int unsigned LINE_MAX = 1024;

    localparam int LIM_W   = 11;
    localparam int BYTE_W  = 8;
    localparam int RES_MAX = 3;

    localparam logic [LIM_W-1:0] LIM_RESET = 11'd256;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h27;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_DOLLAR = 2'd1,
        MODE_NAME   = 2'd2,
        MODE_QUOTE  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [BYTE_W-1:0] prev;
        logic              esc;
        logic [LIM_W-1:0]  sent;
    } scan_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } res_entry_t;

    typedef struct packed {
        logic [1:0]                count;
        res_entry_t [RES_MAX-1:0]  ent;
    } res_set_t;

    localparam scan_state_t STATE_RESET = '{
        mode: MODE_NORMAL, prev: '0, esc: 1'b0, sent: '0
    };

endpackage

`default_nettype wire

>>> src/escq_step.sv
// ----------------------------------------------------------------------------
// escq_step
// Combinational scan step: one input byte to up to three results.
// ----------------------------------------------------------------------------
`default_nettype none

module escq_step (
    input  wire escq_pkg::scan_state_t      st,
    input  wire logic [7:0]                 in_byte,
    input  wire logic                       in_last,
    input  wire logic [10:0]                lim,
    output escq_pkg::scan_state_t           st_next,
    output escq_pkg::res_set_t              res
);
    import escq_pkg::*;

    always_comb
    begin
        scan_state_t      nx;
        res_set_t         r;
        logic             consumed;
        logic             send_a;
        logic             send_b;
        logic [BYTE_W-1:0] byte_a;
        logic [BYTE_W-1:0] byte_b;
        logic [LIM_W:0]   cnt_a;
        logic [LIM_W:0]   cnt_b;
        logic [1:0]       n;

        nx       = st;
        r        = '0;
        consumed = 1'b0;
        send_a   = 1'b0;
        send_b   = 1'b0;
        byte_a   = in_byte;
        byte_b   = in_byte;
        n        = 2'd0;

        // escape handling
        if (st.esc)
        begin
            nx.esc = 1'b0;
        end
        else if (st.mode != MODE_QUOTE && in_byte == CH_BSLASH && st.prev != CH_BSLASH)
        begin
            nx.esc   = 1'b1;
            nx.prev  = CH_BSLASH;
            consumed = 1'b1;
        end

        if (!consumed)
        begin
            unique case (st.mode)
                MODE_NORMAL:
                begin
                    if (in_byte == CH_QUOTE && st.prev != CH_BSLASH)
                        nx.mode = MODE_QUOTE;
                    else if (in_byte == CH_DOLLAR && st.prev != CH_BSLASH)
                        nx.mode = MODE_DOLLAR;
                    else
                        send_a = 1'b1;
                end
                MODE_DOLLAR:
                begin
                    if (in_byte == CH_LPAREN || in_byte == CH_LBRACE)
                    begin
                        nx.mode = MODE_NAME;
                    end
                    else
                    begin
                        nx.mode = MODE_NORMAL;
                        byte_a  = CH_DOLLAR;
                        send_a  = 1'b1;
                        send_b  = 1'b1;
                    end
                end
                MODE_NAME:
                begin
                    if (in_byte == CH_RPAREN || in_byte == CH_RBRACE)
                        nx.mode = MODE_NORMAL;
                end
                MODE_QUOTE:
                begin
                    if (in_byte == CH_QUOTE && st.prev != CH_BSLASH)
                        nx.mode = MODE_NORMAL;
                    else
                        send_a = 1'b1;
                end
                default: ;
            endcase
            nx.prev = in_byte;
        end

        // limited sends: first, then second against the updated count
        cnt_a = {1'b0, st.sent};
        if (send_a && (cnt_a + 1'b1) < {1'b0, lim})
        begin
            r.ent[n] = '{data: byte_a, last: 1'b0};
            n        = n + 2'd1;
            cnt_a    = cnt_a + 1'b1;
        end
        cnt_b = cnt_a;
        if (send_b && (cnt_b + 1'b1) < {1'b0, lim})
        begin
            r.ent[n] = '{data: byte_b, last: 1'b0};
            n        = n + 2'd1;
            cnt_b    = cnt_b + 1'b1;
        end
        nx.sent = cnt_b[LIM_W-1:0];

        // end marker closes the line
        if (in_last)
        begin
            r.ent[n] = '{data: '0, last: 1'b1};
            n        = n + 2'd1;
            nx       = STATE_RESET;
        end

        r.count = n;
        st_next = nx;
        res     = r;
    end

endmodule

`default_nettype wire

>>> src/escq_resq.sv
// ----------------------------------------------------------------------------
// escq_resq
// Result register: holds up to three results, drains one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module escq_resq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire escq_pkg::res_set_t  res,
    output logic                     free,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [7:0]               m_tdata,    // out_byte[7:0]
    output logic                     m_tlast     // out_end
);
    import escq_pkg::*;

    logic [1:0]               count_reg;
    logic [1:0]               count_next;
    res_entry_t [RES_MAX-1:0] ent_reg;
    res_entry_t [RES_MAX-1:0] ent_next;
    logic                     pop;

    assign m_tvalid = (count_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign free     = (count_reg == 2'd0) || (count_reg == 2'd1 && pop);
    assign m_tdata  = ent_reg[0].data;
    assign m_tlast  = ent_reg[0].last;

    always_comb
    begin
        count_next = count_reg;
        ent_next   = ent_reg;
        if (load)
        begin
            count_next = res.count;
            ent_next   = res.ent;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
            ent_next[0] = ent_reg[1];
            ent_next[1] = ent_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

`default_nettype wire

>>> src/escape_quote_macro_filter.sv
// ----------------------------------------------------------------------------
// escape_quote_macro_filter
// Command-line byte filter: unescapes, strips quotes, drops $(..)/${..}.
// ----------------------------------------------------------------------------
// Usage:
//   s_* : input items, tdata = character, tlast = final character of line.
//   m_* : result items, tdata = filtered character, tlast = end marker
//         (tdata 0). Each input item gives zero to three results.
//   cfg_*: write of out_limit (output buffer size); always ready. Write
//         only while the block is idle.
// Path: an accepted item is held in the input register; once the result
//   register is free, its results load into the result register, from
//   which the first result is shown on m_*.
// Throughput: one item per cycle while each item yields at most one result
//   and m_tready is high; an item with more results holds the result
//   register until they drain, one per cycle on m_* while m_tready is high.
// Stall: with m_tready low the result register holds, the input register
//   keeps one more item, then s_tready drops. Nothing is lost.
// Reset: line state clears, limit returns to 256, both registers empty.
// The end-marker item also returns the line state to its reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_quote_macro_filter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // in_byte[7:0]
    input  wire logic        s_tlast,     // in_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,     // out_byte[7:0]
    output logic             m_tlast,     // out_end
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data     // out_limit[10:0], upper bits zero
);
    import escq_pkg::*;

    // limit clamp to the largest honoured buffer size
    localparam logic [LIM_W:0] LIM_CAP =
        (LINE_MAX > 2047) ? 12'd2047 : (LIM_W+1)'(LINE_MAX);

    // input register
    logic              in_vld_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // line state and effective limit
    scan_state_t       st_reg;
    scan_state_t       st_next;
    logic [LIM_W-1:0]  lim_reg;
    logic [LIM_W-1:0]  lim_next;

    res_set_t          res;
    logic              q_free;
    logic              xfer;

    assign xfer      = in_vld_reg && q_free;
    assign s_tready  = !in_vld_reg || xfer;
    assign cfg_ready = 1'b1;

    // effective limit worked out at write time: min(value, cap), at least 1
    always_comb
    begin
        lim_next = lim_reg;
        if (cfg_valid)
        begin
            if ({1'b0, cfg_data[LIM_W-1:0]} > LIM_CAP)
                lim_next = LIM_CAP[LIM_W-1:0];
            else if (cfg_data[LIM_W-1:0] == '0)
                lim_next = LIM_W'(1);
            else
                lim_next = cfg_data[LIM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            st_reg     <= STATE_RESET;
            lim_reg    <= LIM_RESET;
        end
        else
        begin
            lim_reg <= lim_next;
            if (s_tvalid && s_tready)
                in_vld_reg <= 1'b1;
            else if (xfer)
                in_vld_reg <= 1'b0;
            if (xfer)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    escq_step u_step (
        .st      (st_reg),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .lim     (lim_reg),
        .st_next (st_next),
        .res     (res)
    );

    escq_resq u_resq (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (xfer),
        .res      (res),
        .free     (q_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> test/escape_quote_macro_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// escape_quote_macro_filter_tb
// Self-checking bench for the command-line filter. A short directed table
// covers escapes, quotes, $(..)/${..} references, line ends in odd places
// and the limit corner cases. Random lines follow over several limits,
// checked item by item against a behavioural predictor.
// ----------------------------------------------------------------------------

module escape_quote_macro_filter_tb;

    import escq_pkg::*;

    typedef enum bit {ROW_ITEM, ROW_LIMIT} row_kind_t;

    // One line of the directed table: either an input item or a limit write
    typedef struct {
        row_kind_t        kind;
        logic [LIM_W-1:0] val;      // character, or out_limit for ROW_LIMIT
        logic             last;
        bit               typed;    // expectation written by hand in 'want'
        res_set_t         want;
    } stim_row_t;

    localparam res_entry_t NO_RES   = '{data: 8'h00, last: 1'b0};
    localparam res_entry_t END_MARK = '{data: 8'h00, last: 1'b1};

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // in_byte[7:0]
    logic        s_tlast;      // in_last
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;      // out_byte[7:0]
    logic        m_tlast;      // out_end
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;     // out_limit[10:0], upper bits zero

    // Predictor state: one copy of the line scanner and the limit register
    mode_t            scan      = MODE_NORMAL;
    logic [7:0]       last_char = '0;
    logic             esc_held  = 1'b0;
    logic [LIM_W-1:0] line_sent = '0;
    logic [LIM_W-1:0] limit_reg = LIM_RESET;

    res_entry_t       pending_out [$];   // filtered bytes still to arrive
    stim_row_t        dir_rows [$];
    logic [LIM_W-1:0] phase_limit [7];
    int               fail_count = 0;
    bit               burst = 1'b0;      // both sides run without idling

    escape_quote_macro_filter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void put_res(inout res_set_t rs, input logic [7:0] b,
                                    input logic e);
        rs.ent[rs.count] = '{data: b, last: e};
        rs.count++;
    endfunction

    // Emit a byte only while the line stays under the effective limit.
    // The limit saturates at LINE_MAX and a zero limit acts as one.
    function automatic void emit_bounded(inout res_set_t rs, input logic [7:0] b);
        int unsigned eff;
        eff = (limit_reg > LINE_MAX) ? LINE_MAX : limit_reg;
        if (eff == 0)
        begin
            eff = 1;
        end
        if (line_sent + 1 < eff)
        begin
            put_res(rs, b, 1'b0);
            line_sent++;
        end
    endfunction

    // Advance the scanner by one character; returns the bytes it releases
    function automatic res_set_t filter_char(input logic [7:0] c, input logic eol);
        res_set_t rs;
        bit       eaten;
        rs    = '0;
        eaten = 1'b0;

        // An escaping backslash is swallowed and only marks the next byte;
        // inside quotes a backslash is plain text
        if (esc_held)
        begin
            esc_held = 1'b0;
        end
        else if (scan != MODE_QUOTE && c == CH_BSLASH && last_char != CH_BSLASH)
        begin
            esc_held  = 1'b1;
            last_char = CH_BSLASH;
            eaten     = 1'b1;
        end

        if (!eaten)
        begin
            case (scan)
                MODE_NORMAL:
                    if (c == CH_QUOTE && last_char != CH_BSLASH)
                        scan = MODE_QUOTE;
                    else if (c == CH_DOLLAR && last_char != CH_BSLASH)
                        scan = MODE_DOLLAR;
                    else
                        emit_bounded(rs, c);
                MODE_DOLLAR:
                    if (c == CH_LPAREN || c == CH_LBRACE)
                        scan = MODE_NAME;
                    else
                    begin
                        // not a reference after all: '$' first, then the byte
                        scan = MODE_NORMAL;
                        emit_bounded(rs, CH_DOLLAR);
                        emit_bounded(rs, c);
                    end
                MODE_NAME:
                    // variable name is dropped, lookup always comes back empty
                    if (c == CH_RPAREN || c == CH_RBRACE)
                        scan = MODE_NORMAL;
                default:
                    if (c == CH_QUOTE && last_char != CH_BSLASH)
                        scan = MODE_NORMAL;
                    else
                        emit_bounded(rs, c);
            endcase
            last_char = c;
        end

        // End of line: marker item, and the scanner starts afresh
        if (eol)
        begin
            put_res(rs, 8'h00, 1'b1);
            scan      = MODE_NORMAL;
            last_char = '0;
            esc_held  = 1'b0;
            line_sent = '0;
        end
        return rs;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------------

    function automatic res_entry_t ch(input logic [7:0] b);
        return '{data: b, last: 1'b0};
    endfunction

    function automatic res_set_t outs(input int n, input res_entry_t e0 = NO_RES,
                                      input res_entry_t e1 = NO_RES);
        res_set_t rs;
        rs.count  = 2'(n);
        rs.ent[0] = e0;
        rs.ent[1] = e1;
        rs.ent[2] = NO_RES;
        return rs;
    endfunction

    function automatic void typed_row(input logic [7:0] b, input logic l,
                                      input res_set_t w);
        dir_rows.push_back('{kind: ROW_ITEM, val: {3'b0, b}, last: l, typed: 1'b1,
                             want: w});
    endfunction

    function automatic void pred_row(input logic [7:0] b, input logic l);
        dir_rows.push_back('{kind: ROW_ITEM, val: {3'b0, b}, last: l, typed: 1'b0,
                             want: '0});
    endfunction

    function automatic void limit_row(input logic [LIM_W-1:0] v);
        dir_rows.push_back('{kind: ROW_LIMIT, val: v, last: 1'b0, typed: 1'b0,
                             want: '0});
    endfunction

    // ------------------------------------------------------------------------
    // Random line content
    // ------------------------------------------------------------------------

    function automatic logic [7:0] letter();
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    // One of the characters the scanner reacts to
    function automatic logic [7:0] meta_char();
        case ($urandom_range(6))
            0: return CH_DOLLAR;
            1: return CH_LPAREN;
            2: return CH_LBRACE;
            3: return CH_RPAREN;
            4: return CH_RBRACE;
            5: return CH_BSLASH;
            default: return CH_QUOTE;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus tasks. Inputs move on the falling edge; handshakes are
    // sampled on the rising edge.
    // ------------------------------------------------------------------------

    task automatic send_item(input logic [7:0] b, input logic l, input bit typed,
                             input res_set_t want);
        res_set_t got;
        @(negedge clk);
        while (!burst && $urandom_range(99) < 25)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        do
            @(posedge clk);
        while (!s_tready);
        // Accepted: the predictor always advances, hand-typed rows override it
        got = filter_char(b, l);
        if (typed)
        begin
            got = want;
        end
        for (int k = 0; k < got.count; k++)
        begin
            pending_out.push_back(got.ent[k]);
        end
    endtask

    // Limit writes happen only with the block idle: every result in, then a
    // wait for items still in flight that release nothing
    task automatic write_limit(input logic [LIM_W-1:0] lim);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_out.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= {5'b0, lim};
        do
            @(posedge clk);
        while (!cfg_ready);
        limit_reg = lim;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // A mostly well-formed command line with random content
    task automatic send_line(output int n_items);
        logic [7:0] txt [$];
        int         tokens;
        int         pick;
        tokens = $urandom_range(1, 12);
        for (int t = 0; t < tokens; t++)
        begin
            pick = $urandom_range(99);
            if (pick < 25)
                txt.push_back(letter());
            else if (pick < 35)
                txt.push_back(8'($urandom_range(255)));
            else if (pick < 45)
            begin
                // escape pair
                txt.push_back(CH_BSLASH);
                txt.push_back(($urandom_range(1)) ? meta_char() : 8'($urandom_range(255)));
            end
            else if (pick < 57)
            begin
                // quoted text, may hold metacharacters
                txt.push_back(CH_QUOTE);
                repeat ($urandom_range(5))
                    txt.push_back(($urandom_range(3) == 0) ? meta_char() : letter());
                txt.push_back(CH_QUOTE);
            end
            else if (pick < 72)
            begin
                // variable reference $(name) or ${name}
                txt.push_back(CH_DOLLAR);
                txt.push_back(($urandom_range(1)) ? CH_LPAREN : CH_LBRACE);
                repeat ($urandom_range(4))
                    txt.push_back(letter());
                txt.push_back(($urandom_range(1)) ? CH_RPAREN : CH_RBRACE);
            end
            else if (pick < 80)
            begin
                txt.push_back(CH_DOLLAR);
                txt.push_back(8'($urandom_range(255)));
            end
            else if (pick < 90)
                txt.push_back(meta_char());   // stray, breaks sequences
            else
            begin
                txt.push_back(CH_BSLASH);
                txt.push_back(CH_BSLASH);
            end
        end
        for (int k = 0; k < txt.size(); k++)
        begin
            send_item(txt[k], k == txt.size() - 1, 1'b0, '0);
        end
        n_items = txt.size();
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and the checker
    // ------------------------------------------------------------------------

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= burst || ($urandom_range(99) >= 25);
        end
    end

    always @(posedge clk)
    begin
        res_entry_t head;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_out.size() == 0)
            begin
                $error("unexpected result: out_byte %02h out_end %b", m_tdata, m_tlast);
                fail_count++;
            end
            else
            begin
                head = pending_out.pop_front();
                if (m_tdata !== head.data)
                begin
                    $error("out_byte: expected %02h, actual %02h", head.data, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== head.last)
                begin
                    $error("out_end: expected %b, actual %b", head.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        int done;
        int got;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;

        // Directed table
        limit_row(LIM_RESET);
        typed_row(8'h61, 1'b0, outs(1, ch(8'h61)));     // first byte after reset
        typed_row(8'h00, 1'b0, outs(1, ch(8'h00)));     // lowest byte
        typed_row(8'hFF, 1'b0, outs(1, ch(8'hFF)));     // highest byte
        typed_row(CH_BSLASH, 1'b0, outs(0));            // escape swallowed
        pred_row(CH_QUOTE, 1'b0);                       // escaped quote passes
        pred_row(CH_QUOTE, 1'b0);                       // opens literal text
        pred_row(CH_DOLLAR, 1'b0);                      // plain inside quotes
        pred_row(CH_QUOTE, 1'b0);                       // closes
        pred_row(CH_DOLLAR, 1'b0);                      // $() dropped
        pred_row(CH_LPAREN, 1'b0);
        pred_row(CH_RPAREN, 1'b0);
        pred_row(CH_DOLLAR, 1'b0);                      // ${x} dropped
        pred_row(CH_LBRACE, 1'b0);
        pred_row(8'h78, 1'b0);
        pred_row(CH_RBRACE, 1'b0);
        pred_row(CH_DOLLAR, 1'b0);                      // '$' then other byte
        pred_row(8'h61, 1'b0);
        pred_row(CH_BSLASH, 1'b0);                      // double backslash
        pred_row(CH_BSLASH, 1'b0);
        typed_row(8'h7A, 1'b1, outs(2, ch(8'h7A), END_MARK));
        typed_row(CH_BSLASH, 1'b1, outs(1, END_MARK));  // backslash ends line
        pred_row(CH_QUOTE, 1'b0);                       // line ends in quotes
        pred_row(8'h71, 1'b1);
        pred_row(CH_DOLLAR, 1'b0);                      // line ends in a reference
        pred_row(CH_LPAREN, 1'b1);
        limit_row(11'd2);                               // room for one byte only
        typed_row(CH_DOLLAR, 1'b0, outs(0));
        typed_row(8'h61, 1'b1, outs(2, ch(CH_DOLLAR), END_MARK));
        limit_row(11'd0);                               // zero acts as one
        typed_row(8'h78, 1'b1, outs(1, END_MARK));
        limit_row(11'd2047);                            // beyond LINE_MAX
        pred_row(8'h79, 1'b1);

        // Random phases, one limit each; the last limit is drawn at random
        phase_limit = '{11'd8, 11'd1, 11'd3, 11'd2047, 11'd16, 11'd1024, 11'd0};
        phase_limit[6] = 11'($urandom_range(4, 64));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_LIMIT)
                write_limit(dir_rows[i].val);
            else
                send_item(dir_rows[i].val[7:0], dir_rows[i].last, dir_rows[i].typed,
                          dir_rows[i].want);
        end

        for (int p = 0; p < 7; p++)
        begin
            write_limit(phase_limit[p]);
            burst = (p == 4);
            done = 0;
            while (done < 40)
            begin
                send_line(got);
                done += got;
            end
        end
        burst = 1'b0;

        // Drain, then allow the pipeline to settle
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_out.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
